FILE: rtl/ddmo_pkg.sv
// Package for the differential drive mixer and odometry block.
// Holds widths, register indexes, CORDIC constants and the arctangent table.
`timescale 1ns / 1ps
package ddmo_pkg;
   localparam int CordicSteps = 16;
   localparam int PoseWidth = 32;
   localparam int TableLen = 24;
   localparam int RunSteps = (CordicSteps < TableLen) ? CordicSteps : TableLen;
   localparam logic signed [33:0] CordicX0 = 34'sd652032874;
   localparam logic [16:0] HeadScale = 17'd83443;

   localparam logic [2:0] RegMaxLinear = 3'd0;
   localparam logic [2:0] RegMaxAngular = 3'd1;
   localparam logic [2:0] RegWheelBase = 3'd2;
   localparam logic [2:0] RegPwmFloor = 3'd3;
   localparam logic [2:0] RegPwmCeiling = 3'd4;
   localparam logic [2:0] RegDeadBand = 3'd5;

   typedef struct packed {
      logic        op;
      logic [15:0] linear_velocity;
      logic [15:0] angular_velocity;
      logic [15:0] elapsed_time;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [8:0]  left_duty;
      logic [8:0]  right_duty;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [15:0] heading;
      logic [15:0] quat_z;
      logic [15:0] quat_w;
      logic [15:0] held_linear;
      logic [15:0] held_angular;
   } rsp_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
         5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
         5'd14: r = 32'd41721;     5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
         5'd20: r = 32'd652;       5'd21: r = 32'd326;
         5'd22: r = 32'd163;       5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction
endpackage

FILE: rtl/ddmo_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on ddmo_pkg for the payload types.
`timescale 1ns / 1ps
interface ddmo_req_if import ddmo_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ddmo_rsp_if import ddmo_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/diff_drive_mixer_odometry.sv
// Top level of the differential drive mixer and dead-reckoning odometry block.
// Depends on ddmo_pkg, ddmo_if and ddmo_sermul.
//
//   Channel | Direction | Handshake          | Contents
//   req     | in        | valid/ready        | op, velocities, elapsed time
//   rsp     | out       | valid/ready        | PWM pair or pose, held velocity
//   csr     | in/out    | APB, pready high   | six limit and scale registers
//
// Every product runs through the one shift-and-add multiplier at one bit per
// cycle. A command takes one product for the wheel offset, then for each wheel
// that needs the PWM ratio one product and a restoring divide of that product.
// A tick takes five products, two CORDIC passes and the states T_X and T_Q.
// Reset is synchronous and restores the registers and zero pose. The result is
// held in an output register; a stalled result keeps the block from accepting
// the next request, which can be taken in the cycle after the result is accepted.
`timescale 1ns / 1ps
module diff_drive_mixer_odometry import ddmo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ddmo_req_if.sink    req,
   ddmo_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   typedef enum logic [4:0] {
      IDLE, C_OFF, C_OFFW, C_PWM, C_PMUL, C_PMULW, C_DIV, C_NEXT,
      T_VDT, T_VDTW, T_DH1, T_DH1W, T_DH2, T_DH2W, T_COR, T_X, T_XM, T_XW, T_Y, T_YW,
      T_Q, SEND
   } state_type;

   state_type state_ff;
   logic [14:0] max_lin_ff, max_ang_ff, wbase_ff;
   logic [7:0]  floor_ff, ceil_ff, dband_ff;
   logic [PoseWidth-1:0] xpos_ff, ypos_ff;
   logic [15:0] head_ff;
   logic signed [15:0] slin_ff, sang_ff;
   logic [15:0] dt_ff;
   rsp_type out_ff;
   logic valid_ff;

   // Shared multiplier.
   logic mul_start;
   logic signed [47:0] mul_a;
   logic signed [33:0] mul_b;
   logic mul_done;
   logic signed [81:0] mul_p;
   ddmo_sermul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a_in(mul_a), .b_in(mul_b),
      .done(mul_done), .product(mul_p)
   );

   // Work registers. Wheel speeds keep full precision, which can exceed Q4.12.
   logic signed [47:0] opa_ff;
   logic signed [33:0] opb_ff;
   logic signed [47:0] tmp_ff;
   logic signed [18:0] speed_ff;
   logic side_ff;
   logic [8:0] lpwm_ff;
   logic [23:0] rem_ff;
   logic [23:0] num_ff;
   logic [4:0]  cnt_ff;
   logic signed [17:0] offs_ff;
   // CORDIC.
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [33:0] cz_ff;
   logic cneg_ff, cpass_ff;
   logic signed [15:0] cs_ff;

   assign csr_pready = 1'b1;
   wire csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[4:2])
         RegMaxLinear:  csr_prdata = {17'd0, max_lin_ff};
         RegMaxAngular: csr_prdata = {17'd0, max_ang_ff};
         RegWheelBase:  csr_prdata = {17'd0, wbase_ff};
         RegPwmFloor:   csr_prdata = {24'd0, floor_ff};
         RegPwmCeiling: csr_prdata = {24'd0, ceil_ff};
         RegDeadBand:   csr_prdata = {24'd0, dband_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign req.ready = (state_ff == IDLE);
   assign rsp.valid = valid_ff;
   assign rsp.payload = out_ff;
   assign mul_a = opa_ff;
   assign mul_b = opb_ff;
   // The multiplier loads its operands at the edge that leaves a start state, so
   // the operands are always set one state earlier.
   assign mul_start = (state_ff == C_OFF) || (state_ff == C_PMUL) || (state_ff == T_VDT)
      || (state_ff == T_DH1) || (state_ff == T_DH2) || (state_ff == T_XM)
      || (state_ff == T_Y);

   // Round half away from zero of a product by a right shift.
   function automatic logic signed [81:0] rshift(input logic signed [81:0] v,
                                                 input int s);
      logic signed [81:0] h;
      logic signed [81:0] m;
      h = 82'sd1 <<< (s - 1);
      if (v < 0) begin
         m = -v;
         return -((m + h) >>> s);
      end
      return (v + h) >>> s;
   endfunction

   function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
                                                  input logic [14:0] lim);
      logic signed [16:0] l;
      l = {2'b0, lim};
      if (17'(v) > l) return 16'(l);
      if (17'(v) < -l) return 16'(-l);
      return v;
   endfunction

   function automatic logic signed [15:0] cround(input logic signed [33:0] v);
      logic signed [33:0] r;
      r = (v + 34'sd32768) >>> 16;
      if (r > 34'sd16384) r = 34'sd16384;
      if (r < -34'sd16384) r = -34'sd16384;
      return 16'(r);
   endfunction

   logic [4:0] cidx;
   logic signed [33:0] atn;
   assign cidx = 5'(cnt_ff);
   assign atn = 34'(atan_entry(cidx));
   logic [15:0] cang;
   assign cang = cpass_ff ? head_ff : 16'(head_ff << 1);

   // Fold the CORDIC angle into +-90 degrees by a half-turn, which negates the
   // resulting sine and cosine.
   logic signed [16:0] a_raw, a_fold;
   logic a_flip;
   always_comb begin
      a_raw = 17'(signed'(cang));
      a_fold = a_raw;
      a_flip = 1'b0;
      if (a_raw >= 17'sd16384) begin
         a_fold = a_raw - 17'sd32768;
         a_flip = 1'b1;
      end else if (a_raw < -17'sd16384) begin
         a_fold = a_raw + 17'sd32768;
         a_flip = 1'b1;
      end
   end

   wire [17:0] speed_mag = speed_ff[18] ? 18'(-speed_ff) : 18'(speed_ff);
   wire [24:0] trial = {rem_ff, num_ff[23]} - {10'd0, max_lin_ff};
   wire [8:0] span = {1'b0, ceil_ff} - {1'b0, floor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
         max_lin_ff <= 15'd2048; max_ang_ff <= 15'd4096; wbase_ff <= 15'd1229;
         floor_ff <= 8'd80; ceil_ff <= 8'd255; dband_ff <= 8'd4;
         xpos_ff <= '0; ypos_ff <= '0; head_ff <= '0; slin_ff <= '0; sang_ff <= '0;
      end else begin
         if (csr_wr) begin
            unique case (csr_paddr[4:2])
               RegMaxLinear:  max_lin_ff <= csr_pwdata[14:0];
               RegMaxAngular: max_ang_ff <= csr_pwdata[14:0];
               RegWheelBase:  wbase_ff <= csr_pwdata[14:0];
               RegPwmFloor:   floor_ff <= csr_pwdata[7:0];
               RegPwmCeiling: ceil_ff <= csr_pwdata[7:0];
               RegDeadBand:   dband_ff <= csr_pwdata[7:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            IDLE: if (req.valid) begin
               dt_ff <= req.payload.elapsed_time;
               if (!req.payload.op) begin
                  slin_ff <= clamp16(req.payload.linear_velocity, max_lin_ff);
                  sang_ff <= clamp16(req.payload.angular_velocity, max_ang_ff);
                  opa_ff <= 48'(clamp16(req.payload.angular_velocity, max_ang_ff));
                  opb_ff <= {19'd0, wbase_ff};
                  state_ff <= C_OFF;
               end else begin
                  opa_ff <= 48'(slin_ff);
                  opb_ff <= {18'd0, req.payload.elapsed_time};
                  state_ff <= T_VDT;
               end
            end
            C_OFF: state_ff <= C_OFFW;
            C_OFFW: if (mul_done) begin
               offs_ff <= 18'(rshift(mul_p, 13));
               speed_ff <= 19'(slin_ff) - 19'(rshift(mul_p, 13));
               side_ff <= 1'b0;
               state_ff <= C_PWM;
            end
            C_PWM: begin
               if (speed_mag < {10'd0, dband_ff}) begin
                  tmp_ff <= '0; state_ff <= C_NEXT;
               end else if (ceil_ff < floor_ff) begin
                  tmp_ff <= 48'(floor_ff); state_ff <= C_NEXT;
               end else if (max_lin_ff == 15'd0 || speed_mag >= {3'd0, max_lin_ff}) begin
                  tmp_ff <= 48'(ceil_ff); state_ff <= C_NEXT;
               end else begin
                  opa_ff <= 48'(span);
                  opb_ff <= 34'(speed_mag);
                  state_ff <= C_PMUL;
               end
            end
            C_PMUL: state_ff <= C_PMULW;
            C_PMULW: if (mul_done) begin
               num_ff <= 24'(mul_p);
               rem_ff <= '0;
               cnt_ff <= '0;
               state_ff <= C_DIV;
            end
            C_DIV: begin
               // Restoring division, one quotient bit per cycle.
               if (!trial[24]) rem_ff <= trial[23:0];
               else rem_ff <= {rem_ff[22:0], num_ff[23]};
               num_ff <= {num_ff[22:0], !trial[24]};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd23) begin
                  tmp_ff <= 48'({num_ff[22:0], !trial[24]}) + 48'(floor_ff);
                  state_ff <= C_NEXT;
               end
            end
            C_NEXT: begin
               if (!side_ff) begin
                  lpwm_ff <= speed_ff[18] ? -9'(tmp_ff) : 9'(tmp_ff);
                  side_ff <= 1'b1;
                  speed_ff <= 19'(slin_ff) + 19'(offs_ff);
                  state_ff <= C_PWM;
               end else begin
                  out_ff <= '{kind: 1'b0, left_duty: lpwm_ff,
                              right_duty: speed_ff[18] ? -9'(tmp_ff) : 9'(tmp_ff),
                              pos_x: 32'd0, pos_y: 32'd0, heading: 16'd0,
                              quat_z: 16'd0, quat_w: 16'd0,
                              held_linear: slin_ff, held_angular: sang_ff};
                  valid_ff <= 1'b1;
                  state_ff <= SEND;
               end
            end
            T_VDT: state_ff <= T_VDTW;
            T_VDTW: if (mul_done) begin
               tmp_ff <= 48'(mul_p);
               opa_ff <= 48'(sang_ff);
               opb_ff <= {18'd0, dt_ff};
               state_ff <= T_DH1;
            end
            T_DH1: state_ff <= T_DH1W;
            T_DH1W: if (mul_done) begin
               opa_ff <= 48'(mul_p);
               opb_ff <= {17'd0, HeadScale};
               state_ff <= T_DH2;
            end
            T_DH2: state_ff <= T_DH2W;
            T_DH2W: if (mul_done) begin
               offs_ff <= 18'(rshift(mul_p, 32));
               cpass_ff <= 1'b0;
               cnt_ff <= 5'd31;
               state_ff <= T_COR;
            end
            T_COR: begin
               if (cnt_ff == 5'd31) begin
                  cneg_ff <= a_flip;
                  cz_ff <= 34'(a_fold) <<< 16;
                  cx_ff <= CordicX0;
                  cy_ff <= '0;
                  cnt_ff <= '0;
               end else begin
                  if (!cz_ff[33]) begin
                     cx_ff <= cx_ff - (cy_ff >>> cnt_ff);
                     cy_ff <= cy_ff + (cx_ff >>> cnt_ff);
                     cz_ff <= cz_ff - atn;
                  end else begin
                     cx_ff <= cx_ff + (cy_ff >>> cnt_ff);
                     cy_ff <= cy_ff - (cx_ff >>> cnt_ff);
                     cz_ff <= cz_ff + atn;
                  end
                  cnt_ff <= cnt_ff + 5'd1;
                  if (cnt_ff == 5'(RunSteps - 1)) state_ff <= cpass_ff ? T_Q : T_X;
               end
            end
            T_X: begin
               cs_ff <= cneg_ff ? -cround(cy_ff) : cround(cy_ff);
               opa_ff <= tmp_ff;
               opb_ff <= 34'(cneg_ff ? -cround(cx_ff) : cround(cx_ff));
               state_ff <= T_XM;
            end
            T_XM: state_ff <= T_XW;
            T_XW: if (mul_done) begin
               xpos_ff <= xpos_ff + PoseWidth'(rshift(mul_p, 26));
               opb_ff <= 34'(cs_ff);
               state_ff <= T_Y;
            end
            T_Y: state_ff <= T_YW;
            T_YW: if (mul_done) begin
               ypos_ff <= ypos_ff + PoseWidth'(rshift(mul_p, 26));
               head_ff <= head_ff + offs_ff[15:0];
               cpass_ff <= 1'b1;
               cnt_ff <= 5'd31;
               state_ff <= T_COR;
            end
            T_Q: begin
               out_ff <= '{kind: 1'b1, left_duty: 9'd0, right_duty: 9'd0,
                           pos_x: 32'(xpos_ff), pos_y: 32'(ypos_ff), heading: head_ff,
                           quat_z: cneg_ff ? -cround(cy_ff) : cround(cy_ff),
                           quat_w: cneg_ff ? -cround(cx_ff) : cround(cx_ff),
                           held_linear: slin_ff, held_angular: sang_ff};
               valid_ff <= 1'b1;
               state_ff <= SEND;
            end
            SEND: if (rsp.ready) begin
               valid_ff <= 1'b0;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

FILE: rtl/ddmo_sermul.sv
// Shift-and-add serial multiplier, one multiplier bit per cycle, signed operands.
// Depends on ddmo_pkg only for the wildcard import convention.
`timescale 1ns / 1ps
module ddmo_sermul import ddmo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] a_in,
   input  logic signed [33:0] b_in,
   output logic               done,
   output logic signed [81:0] product
);
   logic signed [81:0] acc_ff, acc_in;
   logic signed [81:0] mcand_ff, mcand_in;
   logic [33:0]        mplier_ff, mplier_in;
   logic [5:0]         count_ff, count_in;
   logic               busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mcand_in = 82'(a_in);
         mplier_in = b_in;
         count_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The top bit of the multiplier carries negative weight.
         if (mplier_ff[0]) begin
            if (count_ff == 6'd33) acc_in = acc_ff - mcand_ff;
            else acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd33) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      count_ff <= count_in;
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule

FILE: rtl/ddmo_checker.sv
// Port-level assertions for diff_drive_mixer_odometry, bound to the top level.
// Depends on ddmo_pkg and the channel interfaces.
`timescale 1ns / 1ps
module ddmo_checker import ddmo_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped or changed while stalled");
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with result pending");
   a_pwm_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.kind |-> rsp_payload.pos_x == 32'd0
      && rsp_payload.heading == 16'd0) else $error("PWM result carries pose");
   a_pose_pwm_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind |-> rsp_payload.left_duty == 9'd0
      && rsp_payload.right_duty == 9'd0) else $error("pose result carries PWM");
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");
endmodule

bind diff_drive_mixer_odometry ddmo_checker u_ddmo_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

FILE: dv/tb.sv
// Self-checking testbench for diff_drive_mixer_odometry.
// Depends on ddmo_pkg, the ddmo_if channel interfaces and the block's RTL.
`timescale 1ns / 1ps
module tb;
   import ddmo_pkg::*;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   ddmo_req_if req_ch ();
   ddmo_rsp_if rsp_ch ();

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   diff_drive_mixer_odometry uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Arctangent of 2^-i in a 32-bit binary angle, for the sine/cosine predictor.
   localparam longint ArcTab [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41721, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   // Mirror of the block's registers and odometry state.
   longint    lim_lin, lim_ang, base_len, duty_lo, duty_hi, band;
   logic [31:0] odo_x, odo_y;
   logic [15:0] odo_head;
   longint    vel_lin, vel_ang;

   rsp_type   pending_rsp [$];
   int        errors = 0;
   int        reported = 0;
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        n_cmd = 0;
   int        n_tick = 0;
   int        n_rsp = 0;
   int        n_cfg = 0;
   int        quiet = 0;

   function automatic longint rnd_half_away(longint v, int s);
      longint half;
      half = longint'(1) <<< (s - 1);
      if (v < 0) return -((-v + half) >>> s);
      return (v + half) >>> s;
   endfunction

   function automatic longint sym_clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Cosine and sine of a 16-bit binary angle, Q1.14.
   task automatic sin_cos(input logic [15:0] angle, output longint c, output longint s);
      longint a, x, y, z, dx, dy;
      bit     flip;
      a = longint'($signed(angle));
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (a >= 16384) begin
         a -= 32768;
         flip = 1'b1;
      end else if (a < -16384) begin
         a += 32768;
         flip = 1'b1;
      end
      z = a * 65536;
      for (int i = 0; i < RunSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ArcTab[i];
         end else begin
            x += dx; y -= dy; z += ArcTab[i];
         end
      end
      c = sym_clip((x + 32768) >>> 16, 16384);
      s = sym_clip((y + 32768) >>> 16, 16384);
      if (flip) begin
         c = -c;
         s = -s;
      end
   endtask

   function automatic longint wheel_duty(longint speed);
      longint mag, p;
      mag = speed < 0 ? -speed : speed;
      if (mag < band) return 0;
      if (duty_hi < duty_lo) p = duty_lo;
      else if (lim_lin == 0 || mag >= lim_lin) p = duty_hi;
      else p = duty_lo + ((duty_hi - duty_lo) * mag) / lim_lin;
      return speed < 0 ? -p : p;
   endfunction

   // Advance the mirror by one request and return the result it should give.
   task automatic mix_or_integrate(input req_type rq, output rsp_type r);
      longint v, w, off, dt, vdt, dh, c, s, qw, qz;
      r = '0;
      if (rq.op == 1'b0) begin
         v = sym_clip(longint'($signed(rq.linear_velocity)), lim_lin);
         w = sym_clip(longint'($signed(rq.angular_velocity)), lim_ang);
         off = rnd_half_away(w * base_len, 13);
         r.left_duty = 9'(wheel_duty(v - off));
         r.right_duty = 9'(wheel_duty(v + off));
         vel_lin = v;
         vel_ang = w;
      end else begin
         dt = longint'(rq.elapsed_time);
         vdt = vel_lin * dt;
         dh = rnd_half_away(vel_ang * dt * 83443, 32);
         sin_cos(odo_head << 1, c, s);
         odo_x = odo_x + 32'(rnd_half_away(vdt * c, 26));
         odo_y = odo_y + 32'(rnd_half_away(vdt * s, 26));
         odo_head = odo_head + 16'(dh);
         sin_cos(odo_head, qw, qz);
         r.kind = 1'b1;
         r.pos_x = odo_x;
         r.pos_y = odo_y;
         r.heading = odo_head;
         r.quat_z = 16'(qz);
         r.quat_w = 16'(qw);
      end
      r.held_linear = 16'(vel_lin);
      r.held_angular = 16'(vel_ang);
   endtask

   // Receiver: random stalls, set at the falling edge.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Result checker: every accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("ERROR: unexpected result %h", rsp_ch.payload);
            end
         end else if (rsp_ch.payload !== pending_rsp[0]) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("ERROR: result mismatch");
               $display("  expected kind=%0d pwm=%0d/%0d x=%h y=%h hd=%h qz=%h qw=%h v=%h w=%h",
                  pending_rsp[0].kind, $signed(pending_rsp[0].left_duty),
                  $signed(pending_rsp[0].right_duty), pending_rsp[0].pos_x,
                  pending_rsp[0].pos_y, pending_rsp[0].heading, pending_rsp[0].quat_z,
                  pending_rsp[0].quat_w, pending_rsp[0].held_linear,
                  pending_rsp[0].held_angular);
               $display("  actual   kind=%0d pwm=%0d/%0d x=%h y=%h hd=%h qz=%h qw=%h v=%h w=%h",
                  rsp_ch.payload.kind, $signed(rsp_ch.payload.left_duty),
                  $signed(rsp_ch.payload.right_duty), rsp_ch.payload.pos_x,
                  rsp_ch.payload.pos_y, rsp_ch.payload.heading, rsp_ch.payload.quat_z,
                  rsp_ch.payload.quat_w, rsp_ch.payload.held_linear,
                  rsp_ch.payload.held_angular);
            end
         end
         if (pending_rsp.size() != 0) pending_rsp.pop_front();
      end
   end

   // Watchdog: cycles with no request, result or register access accepted.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_psel && csr_penable) || reset)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= 20000) begin
         $display("Watchdog expired with %0d results outstanding", pending_rsp.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // One request onto the channel; the mirror is advanced when it is accepted.
   // A typed expectation, when given, replaces the predicted one.
   task automatic send_request(input req_type rq, input bit typed, input rsp_type typed_rsp);
      rsp_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.payload <= rq;
      do @(posedge clock); while (!req_ch.ready);
      mix_or_integrate(rq, r);
      pending_rsp.push_back(typed ? typed_rsp : r);
      if (rq.op) n_tick++; else n_cmd++;
   endtask

   task automatic drain;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // APB write of one register, then a read back of it.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] masked;
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      n_cfg++;
      masked = (idx <= RegWheelBase) ? (value & 32'h7FFF) : (value & 32'hFF);
      case (idx)
         RegMaxLinear: lim_lin = masked;
         RegMaxAngular: lim_ang = masked;
         RegWheelBase: base_len = masked;
         RegPwmFloor: duty_lo = masked;
         RegPwmCeiling: duty_hi = masked;
         RegDeadBand: band = masked;
         default: ;
      endcase
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx <= RegDeadBand && csr_prdata !== masked) begin
         errors++;
         if (reported < 10) begin
            reported++;
            $display("ERROR: register %0d read %h, expected %h", idx, csr_prdata, masked);
         end
      end
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0;
   endtask

   task automatic set_limits(input longint ml, ma, wb, lo, hi, db);
      write_reg(RegMaxLinear, 32'(ml));
      write_reg(RegMaxAngular, 32'(ma));
      write_reg(RegWheelBase, 32'(wb));
      write_reg(RegPwmFloor, 32'(lo));
      write_reg(RegPwmCeiling, 32'(hi));
      write_reg(RegDeadBand, 32'(db));
   endtask

   function automatic req_type mk_req(logic op, logic [15:0] v, logic [15:0] w,
                                      logic [15:0] dt);
      req_type rq;
      rq.op = op;
      rq.linear_velocity = v;
      rq.angular_velocity = w;
      rq.elapsed_time = dt;
      return rq;
   endfunction

   function automatic rsp_type mk_duty(logic [8:0] l, logic [8:0] r,
                                       logic [15:0] hv, logic [15:0] hw);
      rsp_type x;
      x = '0;
      x.left_duty = l;
      x.right_duty = r;
      x.held_linear = hv;
      x.held_angular = hw;
      return x;
   endfunction

   // Random request: commands and ticks in equal measure, mostly with velocities up to
   // 100 beyond the limits and elapsed times up to 8000, with full-range noise mixed in.
   function automatic req_type random_request();
      req_type rq;
      int      k;
      rq = req_type'(49'({$urandom, $urandom}));
      rq.op = 1'($urandom_range(1));
      k = $urandom_range(9);
      if (k < 6) begin
         rq.linear_velocity = 16'($signed(32'($urandom_range(2 * lim_lin + 200))) -
                              $signed(32'(lim_lin + 100)));
         rq.angular_velocity = 16'($signed(32'($urandom_range(2 * lim_ang + 200))) -
                               $signed(32'(lim_ang + 100)));
      end
      if (k < 7) rq.elapsed_time = 16'($urandom_range(8000));
      return rq;
   endfunction

   typedef struct {
      req_type rq;
      bit      typed;
      rsp_type want;
   } row_t;

   row_t    plan [$];
   rsp_type none;
   longint  ml, ma, wb, lo, hi, db;

   initial begin
      none = '0;
      lim_lin = 2048; lim_ang = 4096; base_len = 1229;
      duty_lo = 80; duty_hi = 255; band = 4;
      odo_x = '0; odo_y = '0; odo_head = '0;
      vel_lin = 0; vel_ang = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. A tick straight after reset stays at the origin, and
      // commands far beyond the limits clamp to full scale.
      begin
         rsp_type home;
         home = '0;
         home.kind = 1'b1;
         home.quat_w = 16'd16384;
         plan.push_back('{mk_req(1, 0, 0, 16'hFFFF), 1, home});
         plan.push_back('{mk_req(0, 0, 0, 0), 1, mk_duty(0, 0, 0, 0)});
         plan.push_back('{mk_req(0, 16'h7FFF, 0, 0), 1,
                          mk_duty(9'sd255, 9'sd255, 16'd2048, 0)});
         plan.push_back('{mk_req(0, 16'h8000, 0, 0), 1,
                          mk_duty(-9'sd255, -9'sd255, -16'sd2048, 0)});
         plan.push_back('{mk_req(1, 0, 0, 16'hFFFF), 0, none});
      end
      plan.push_back('{mk_req(0, 0, 16'h7FFF, 0), 0, none});
      plan.push_back('{mk_req(1, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, none});
      plan.push_back('{mk_req(0, 0, 16'h8000, 16'hFFFF), 0, none});
      plan.push_back('{mk_req(1, 0, 0, 16'hFFFF), 0, none});
      plan.push_back('{mk_req(0, 3, 0, 0), 0, none});
      plan.push_back('{mk_req(0, 4, 0, 0), 0, none});
      plan.push_back('{mk_req(0, 16'hFFFC, 0, 0), 0, none});
      plan.push_back('{mk_req(0, 1500, 16'd3000, 0), 0, none});
      plan.push_back('{mk_req(1, 0, 0, 0), 0, none});
      plan.push_back('{mk_req(1, 0, 0, 16'd3277), 0, none});
      plan.push_back('{mk_req(1, 0, 0, 16'hFFFF), 0, none});
      plan.push_back('{mk_req(0, 16'h8000, 16'h7FFF, 0), 0, none});
      plan.push_back('{mk_req(1, 0, 0, 16'h8000), 0, none});
      plan.push_back('{mk_req(1, 0, 0, 16'hFFFF), 0, none});
      foreach (plan[i]) send_request(plan[i].rq, plan[i].typed, plan[i].want);
      drain();

      // Ceiling below floor, zero limits and writes to unused addresses.
      set_limits(0, 0, 32767, 200, 50, 0);
      write_reg(3'd6, 32'hFFFF_FFFF);
      write_reg(3'd7, 32'hFFFF_FFFF);
      send_request(mk_req(0, 16'd100, 16'd100, 0), 0, none);
      send_request(mk_req(0, 0, 0, 0), 0, none);
      send_request(mk_req(1, 0, 0, 16'hFFFF), 0, none);
      drain();

      // Random phases, each with its own register setting and one of four idling patterns.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin ml = 2048; ma = 4096; wb = 1229; lo = 80; hi = 255; db = 4; end
            1: begin ml = 1; ma = 1; wb = 0; lo = 0; hi = 0; db = 0; end
            2: begin ml = 32767; ma = 32767; wb = 32767; lo = 255; hi = 255; db = 255; end
            3: begin ml = 0; ma = 32767; wb = 32767; lo = 0; hi = 255; db = 255; end
            4: begin ml = 4096; ma = 0; wb = 2000; lo = 180; hi = 40; db = 10; end
            default: begin
               ml = $urandom_range(32767); ma = $urandom_range(32767);
               wb = $urandom_range(32767); lo = $urandom_range(255);
               hi = $urandom_range(255); db = $urandom_range(255);
            end
         endcase
         set_limits(ml, ma, wb, lo, hi, db);
         case (ph % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 49; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 49; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         for (int n = 0; n < 205; n++) begin
            // Halfway through the third phase the sender holds off until the
            // block has returned everything it owes.
            if (ph == 2 && n == 100) begin
               @(negedge clock);
               req_ch.valid <= 1'b0;
               while (pending_rsp.size() != 0) @(posedge clock);
            end
            send_request(random_request(), 0, none);
         end
         drain();
      end

      repeat (400) @(posedge clock);
      $display("Covered %0d commands and %0d ticks, %0d results, %0d register accesses,",
               n_cmd, n_tick, n_rsp, n_cfg);
      $display("over limit extremes and four idle/stall patterns.");
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, pending_rsp.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

FILE: diff_drive_mixer_odometry.f
rtl/ddmo_pkg.sv
rtl/ddmo_if.sv
rtl/ddmo_sermul.sv
rtl/diff_drive_mixer_odometry.sv
rtl/ddmo_checker.sv
dv/tb.sv
